@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/wsfs_pkg.sv @@
// shared types and constants of the ws2812 frame serializer
package wsfs_pkg;

   typedef enum logic [1:0] {
      REQ_SET   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_SHOW  = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_HIGH_TIME_ZERO  = 2'd0,
      CSR_HIGH_TIME_ONE   = 2'd1,
      CSR_LEAD_SLOT_COUNT = 2'd2,
      CSR_TAIL_SLOT_COUNT = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int LEVEL_W     = 16;
   localparam int COUNT_W     = 10;
   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int STRIPS      = 2;

   localparam int BITS_PER_LED   = 24;
   localparam int MAX_SLOT_COUNT = 1023;

   // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 1024
   localparam int DIV3_MUL   = 1366;
   localparam int DIV3_MUL_W = 11;
   localparam int DIV3_SHIFT = 12;

   localparam logic [4:0] LED_BIT_MSB = 5'd23;

   localparam logic [LEVEL_W-1:0] RESET_HIGH_TIME_ZERO  = 16'd84;
   localparam logic [LEVEL_W-1:0] RESET_HIGH_TIME_ONE   = 16'd168;
   localparam logic [COUNT_W-1:0] RESET_LEAD_SLOT_COUNT = 10'd48;
   localparam logic [COUNT_W-1:0] RESET_TAIL_SLOT_COUNT = 10'd48;

endpackage

@@ hw/rtl/wsfs_if.sv @@
// request and response channel interfaces

interface wsfs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       strip_select;
   logic [7:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output req_type, output strip_select,
                   output pixel_index, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input req_type, input strip_select,
                   input pixel_index, input red, input green, input blue,
                   output ready);
endinterface

interface wsfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        show_accepted;
   logic [15:0] level_strip_zero;
   logic [15:0] level_strip_one;
   logic        busy_strip_zero;
   logic        busy_strip_one;

   modport source (output valid, output show_accepted, output level_strip_zero,
                   output level_strip_one, output busy_strip_zero,
                   output busy_strip_one, input ready);
   modport sink   (input valid, input show_accepted, input level_strip_zero,
                   input level_strip_one, input busy_strip_zero,
                   input busy_strip_one, output ready);
endinterface

@@ hw/rtl/wsfs_ram.sv @@
// generic single write port ram with registered read
module wsfs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/ws2812_frame_serializer_top.sv @@
// two-strip ws2812 pixel store and pulse-width slot serializer
//
// requests come in on req_chan: set pixel, clear strip, show strip and
// slot tick. every request gives exactly one response on rsp_chan with the
// show status, the compare value of each strip for a tick and both busy
// flags as they stand after the request.
// csr_we/csr_index/csr_wdata write the bit compare values and the lead and
// tail slot counts; write them only while no request is in flight.
// a request passes the per-strip pixel ram read stage and then the
// response register. one request is taken every cycle while the
// receiver takes responses; each strip has its own ram with one read and
// one write port, and each entry has two banks so that a show swaps in
// the snapshot by flag copy instead of moving pixel data.
// reset clears the pixel store at once through per-entry zero flags, so
// there is no clearing pass. when the receiver stalls, the response
// register holds, one more request is taken into the ram read stage, and
// then req_chan.ready drops until the response is taken.
`include "assert_macros.svh"

module ws2812_frame_serializer_top #(
   parameter int LEDS_PER_STRIP = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   wsfs_req_if.sink                           req_chan,
   wsfs_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [wsfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wsfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DATA_SLOTS = LEDS_PER_STRIP * wsfs_pkg::BITS_PER_LED;
   localparam int POS_W = $clog2(2 * wsfs_pkg::MAX_SLOT_COUNT + DATA_SLOTS + 1);
   localparam int LED_W = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
   localparam int ADDR_W = LED_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int X_W = POS_W - 3;
   localparam int PROD_W = X_W + wsfs_pkg::DIV3_MUL_W;
   localparam int Q_W = PROD_W - wsfs_pkg::DIV3_SHIFT;
   localparam int STRIPS = wsfs_pkg::STRIPS;

   typedef struct packed {
      logic              show_accepted;
      logic [STRIPS-1:0] busy;
      logic [STRIPS-1:0] in_data;
      logic [STRIPS-1:0] zero;
      logic [4:0]        bit_pos_zero;
      logic [4:0]        bit_pos_one;
   } stage_type;

   // configuration registers
   logic [wsfs_pkg::LEVEL_W-1:0] high_zero_ff;
   logic [wsfs_pkg::LEVEL_W-1:0] high_one_ff;
   logic [wsfs_pkg::COUNT_W-1:0] lead_ff;
   logic [wsfs_pkg::COUNT_W-1:0] tail_ff;

   // per strip frame state
   logic [STRIPS-1:0] busy_ff, busy_in;
   logic [POS_W-1:0]  pos_ff [STRIPS];
   logic [POS_W-1:0]  pos_in [STRIPS];

   // per entry bank select and zero flags, live store and send snapshot
   logic [LEDS_PER_STRIP-1:0] live_sel_ff [STRIPS];
   logic [LEDS_PER_STRIP-1:0] live_sel_in [STRIPS];
   logic [LEDS_PER_STRIP-1:0] live_zero_ff [STRIPS];
   logic [LEDS_PER_STRIP-1:0] live_zero_in [STRIPS];
   logic [LEDS_PER_STRIP-1:0] send_sel_ff [STRIPS];
   logic [LEDS_PER_STRIP-1:0] send_sel_in [STRIPS];
   logic [LEDS_PER_STRIP-1:0] send_zero_ff [STRIPS];
   logic [LEDS_PER_STRIP-1:0] send_zero_in [STRIPS];

   // ram read stage
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_show_ff, rsp_show_in;
   logic [wsfs_pkg::LEVEL_W-1:0] rsp_level_ff [STRIPS];
   logic [wsfs_pkg::LEVEL_W-1:0] rsp_level_in [STRIPS];
   logic [STRIPS-1:0]            rsp_busy_ff, rsp_busy_in;

   logic                   req_ready;
   logic                   req_acc;
   logic                   s1_adv;
   wsfs_pkg::req_kind_type req_kind;
   logic                   idx_ok;
   logic [LED_W-1:0]       wr_led;
   logic [wsfs_pkg::PIXEL_W-1:0] wr_word;

   logic [POS_W-1:0] data_start, data_end, total;
   logic [POS_W-1:0] dofs    [STRIPS];
   logic [PROD_W-1:0] prod   [STRIPS];
   logic [Q_W-1:0]   quot    [STRIPS];
   logic [LED_W-1:0] rd_led  [STRIPS];
   logic [4:0]       rem     [STRIPS];
   logic [4:0]       bit_pos [STRIPS];
   logic [STRIPS-1:0] in_data;

   logic [STRIPS-1:0]              ram_we, ram_re;
   logic [ADDR_W-1:0]              ram_waddr [STRIPS];
   logic [ADDR_W-1:0]              ram_raddr [STRIPS];
   logic [wsfs_pkg::PIXEL_W-1:0]   ram_rdata [STRIPS];

   // ---------------------------------------------------------------
   // handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign req_kind = wsfs_pkg::req_kind_type'(req_chan.req_type);
   assign idx_ok   = req_chan.pixel_index < 8'(LEDS_PER_STRIP);
   assign wr_led   = req_chan.pixel_index[LED_W-1:0];
   assign wr_word  = {req_chan.green, req_chan.red, req_chan.blue};

   // ---------------------------------------------------------------
   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         high_zero_ff <= wsfs_pkg::RESET_HIGH_TIME_ZERO;
         high_one_ff  <= wsfs_pkg::RESET_HIGH_TIME_ONE;
         lead_ff      <= wsfs_pkg::RESET_LEAD_SLOT_COUNT;
         tail_ff      <= wsfs_pkg::RESET_TAIL_SLOT_COUNT;
      end else if (csr_we) begin
         case (wsfs_pkg::csr_index_type'(csr_index))
            wsfs_pkg::CSR_HIGH_TIME_ZERO: begin
               high_zero_ff <= csr_wdata;
            end
            wsfs_pkg::CSR_HIGH_TIME_ONE: begin
               high_one_ff <= csr_wdata;
            end
            wsfs_pkg::CSR_LEAD_SLOT_COUNT: begin
               lead_ff <= csr_wdata[wsfs_pkg::COUNT_W-1:0];
            end
            wsfs_pkg::CSR_TAIL_SLOT_COUNT: begin
               tail_ff <= csr_wdata[wsfs_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // slot position decode
   assign data_start = POS_W'(lead_ff);
   assign data_end   = data_start + POS_W'(DATA_SLOTS);
   assign total      = data_end + POS_W'(tail_ff);

   always_comb begin
      for (int s = 0; s < STRIPS; s++) begin
         in_data[s] = busy_ff[s] && (pos_ff[s] >= data_start) && (pos_ff[s] < data_end);
         dofs[s]    = pos_ff[s] - data_start;
         // led = offset / 24 as (offset / 8) / 3 by reciprocal
         prod[s]    = PROD_W'(dofs[s][POS_W-1:3]) * PROD_W'(wsfs_pkg::DIV3_MUL);
         quot[s]    = prod[s][PROD_W-1:wsfs_pkg::DIV3_SHIFT];
         rd_led[s]  = quot[s][LED_W-1:0];
         rem[s]     = dofs[s][4:0] - {quot[s][1:0], 3'b000} - {quot[s][0], 4'b0000};
         bit_pos[s] = wsfs_pkg::LED_BIT_MSB - rem[s];
      end
   end

   // ---------------------------------------------------------------
   // frame state and flag updates
   always_comb begin
      for (int s = 0; s < STRIPS; s++) begin
         busy_in[s]      = busy_ff[s];
         pos_in[s]       = pos_ff[s];
         live_sel_in[s]  = live_sel_ff[s];
         live_zero_in[s] = live_zero_ff[s];
         send_sel_in[s]  = send_sel_ff[s];
         send_zero_in[s] = send_zero_ff[s];
         if (req_acc) begin
            case (req_kind)
               wsfs_pkg::REQ_SET: begin
                  // write the bank the snapshot does not use
                  if (idx_ok && req_chan.strip_select == 1'(s)) begin
                     live_sel_in[s][wr_led]  = ~send_sel_ff[s][wr_led];
                     live_zero_in[s][wr_led] = 1'b0;
                  end
               end
               wsfs_pkg::REQ_CLEAR: begin
                  if (req_chan.strip_select == 1'(s)) begin
                     live_zero_in[s] = '1;
                  end
               end
               wsfs_pkg::REQ_SHOW: begin
                  if (req_chan.strip_select == 1'(s) && !busy_ff[s]) begin
                     send_sel_in[s]  = live_sel_ff[s];
                     send_zero_in[s] = live_zero_ff[s];
                     busy_in[s]      = 1'b1;
                     pos_in[s]       = '0;
                  end
               end
               wsfs_pkg::REQ_TICK: begin
                  if (busy_ff[s]) begin
                     if (pos_ff[s] >= total || pos_ff[s] + POS_W'(1) >= total) begin
                        busy_in[s] = 1'b0;
                        pos_in[s]  = '0;
                     end else begin
                        pos_in[s] = pos_ff[s] + POS_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int s = 0; s < STRIPS; s++) begin
            pos_ff[s]       <= '0;
            live_sel_ff[s]  <= '0;
            live_zero_ff[s] <= '1;
            send_sel_ff[s]  <= '0;
            send_zero_ff[s] <= '1;
         end
      end else begin
         busy_ff <= busy_in;
         for (int s = 0; s < STRIPS; s++) begin
            pos_ff[s]       <= pos_in[s];
            live_sel_ff[s]  <= live_sel_in[s];
            live_zero_ff[s] <= live_zero_in[s];
            send_sel_ff[s]  <= send_sel_in[s];
            send_zero_ff[s] <= send_zero_in[s];
         end
      end
   end

   // ---------------------------------------------------------------
   // pixel rams, one per strip, entry address is {led, bank}
   always_comb begin
      for (int s = 0; s < STRIPS; s++) begin
         ram_we[s] = req_acc && (req_kind == wsfs_pkg::REQ_SET) && idx_ok
                     && (req_chan.strip_select == 1'(s));
         ram_waddr[s] = {wr_led, ~send_sel_ff[s][wr_led]};
         ram_re[s]    = req_acc && (req_kind == wsfs_pkg::REQ_TICK) && in_data[s];
         ram_raddr[s] = {rd_led[s], send_sel_ff[s][rd_led[s]]};
      end
   end

   for (genvar g = 0; g < STRIPS; g++) begin : g_strip_ram
      wsfs_ram #(
         .WIDTH (wsfs_pkg::PIXEL_W),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[g]),
         .waddr (ram_waddr[g]),
         .wdata (wr_word),
         .re    (ram_re[g]),
         .raddr (ram_raddr[g]),
         .rdata (ram_rdata[g])
      );
   end

   // ---------------------------------------------------------------
   // ram read stage
   always_comb begin
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_in.show_accepted = (req_kind == wsfs_pkg::REQ_SHOW)
                            && !busy_ff[req_chan.strip_select];
      s1_in.busy = busy_in;
      for (int s = 0; s < STRIPS; s++) begin
         s1_in.in_data[s] = (req_kind == wsfs_pkg::REQ_TICK) && in_data[s];
         s1_in.zero[s]    = send_zero_ff[s][rd_led[s]];
      end
      s1_in.bit_pos_zero = bit_pos[0];
      s1_in.bit_pos_one  = bit_pos[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------
   // response register
   always_comb begin
      logic [1:0] bit_set;
      bit_set[0] = !s1_ff.zero[0] && ram_rdata[0][s1_ff.bit_pos_zero];
      bit_set[1] = !s1_ff.zero[1] && ram_rdata[1][s1_ff.bit_pos_one];
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_show_in  = s1_ff.show_accepted;
      rsp_busy_in  = s1_ff.busy;
      for (int s = 0; s < STRIPS; s++) begin
         if (!s1_ff.in_data[s]) begin
            rsp_level_in[s] = '0;
         end else if (bit_set[s]) begin
            rsp_level_in[s] = high_one_ff;
         end else begin
            rsp_level_in[s] = high_zero_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         rsp_show_ff <= rsp_show_in;
         rsp_busy_ff <= rsp_busy_in;
         for (int s = 0; s < STRIPS; s++) begin
            rsp_level_ff[s] <= rsp_level_in[s];
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.show_accepted    = rsp_show_ff;
   assign rsp_chan.level_strip_zero = rsp_level_ff[0];
   assign rsp_chan.level_strip_one  = rsp_level_ff[1];
   assign rsp_chan.busy_strip_zero  = rsp_busy_ff[0];
   assign rsp_chan.busy_strip_one   = rsp_busy_ff[1];

   // ---------------------------------------------------------------
   // assertions
   `ASSERT_ALWAYS(idle_pos_zero, clock, reset, busy_ff[0] || (pos_ff[0] == '0))
   `ASSERT_NEXT(read_lands_in_stage, clock, reset, (ram_re != '0), s1_valid_ff)
   `ASSERT_NEXT(show_starts_frame, clock, reset,
      req_acc && (req_kind == wsfs_pkg::REQ_SHOW) && !req_chan.strip_select && !busy_ff[0],
      busy_ff[0] && (pos_ff[0] == '0))

endmodule
